// ===== rtl/csvt_pkg.sv =====
// Shared types, character constants and register codes for the CSV field tokenizer.
`timescale 1ns / 1ps

package csvt_pkg;

    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_COMMA = 8'h2C;

    localparam int unsigned N_EXTRA_DELIM = 4;
    localparam int unsigned MAX_RESULTS   = 3;
    localparam int unsigned PADDR_W       = 4;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        REG_EXTRA_DELIM_0 = 2'd0,
        REG_EXTRA_DELIM_1 = 2'd1,
        REG_EXTRA_DELIM_2 = 2'd2,
        REG_EXTRA_DELIM_3 = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_PLAIN   = 3'd1,
        M_QUOTED  = 3'd2,
        M_QPEND   = 3'd3,
        M_AFTERCR = 3'd4,
        M_STOP    = 3'd5
    } t_mode;

    typedef logic [N_EXTRA_DELIM-1:0][7:0] t_delims;

    // Everything one byte produces: next mode and up to three results.
    typedef struct packed {
        t_mode                        mode;
        logic [1:0]                   cnt;
        logic [MAX_RESULTS-1:0]       kind;
        logic [MAX_RESULTS-1:0][7:0]  chr;
    } t_step_res;

endpackage

// ===== rtl/csvt_step.sv =====
// Per-byte parse logic: next mode and the list of results for one input byte.
`timescale 1ns / 1ps

module csvt_step
    import csvt_pkg::*;
(
    input  t_mode      i_mode,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_line,
    input  t_delims    i_delims,
    output t_step_res  o_res
);

    logic       is_delim;
    logic       extra_hit;
    t_mode      sb_mode;
    logic       sb_emit;
    logic       sb_kind;
    logic [7:0] sb_chr;
    t_step_res  res;

    always_comb begin
        extra_hit = 1'b0;
        for (int i = 0; i < N_EXTRA_DELIM; i++) begin
            if (i_delims[i] == i_data_byte) extra_hit = 1'b1;
        end
        is_delim = (i_data_byte == C_COMMA) || (i_data_byte == C_TAB) ||
                   ((i_data_byte != C_NUL) && extra_hit);
    end

    // Handling of a byte between fields
    always_comb begin
        sb_emit = 1'b0;
        sb_kind = KIND_END;
        sb_chr  = '0;
        if (i_data_byte == C_NUL) begin
            sb_mode = M_STOP;
        end else if (i_data_byte == C_QUOTE) begin
            sb_mode = M_QUOTED;
        end else if (is_delim) begin
            sb_emit = 1'b1;
            sb_mode = M_IDLE;
        end else if (i_data_byte == C_CR) begin
            sb_emit = 1'b1;
            sb_mode = M_AFTERCR;
        end else if (i_data_byte == C_LF) begin
            sb_emit = 1'b1;
            sb_mode = M_IDLE;
        end else begin
            sb_emit = 1'b1;
            sb_kind = KIND_CHAR;
            sb_chr  = i_data_byte;
            sb_mode = M_PLAIN;
        end
    end

    always_comb begin
        res      = '0;
        res.mode = i_mode;
        unique case (i_mode)
            M_PLAIN: begin
                if (i_data_byte == C_NUL || is_delim || i_data_byte == C_CR ||
                    i_data_byte == C_LF) begin
                    res.kind[res.cnt] = KIND_END;
                    res.cnt = res.cnt + 2'd1;
                    if (i_data_byte == C_NUL) res.mode = M_STOP;
                    else if (is_delim) res.mode = M_IDLE;
                    else if (i_data_byte == C_CR) res.mode = M_AFTERCR;
                    else res.mode = M_IDLE;
                end else begin
                    res.kind[res.cnt] = KIND_CHAR;
                    res.chr[res.cnt] = i_data_byte;
                    res.cnt = res.cnt + 2'd1;
                end
            end
            M_QUOTED: begin
                if (i_data_byte == C_NUL) begin
                    res.kind[res.cnt] = KIND_END;
                    res.cnt = res.cnt + 2'd1;
                    res.mode = M_STOP;
                end else if (i_data_byte == C_QUOTE) begin
                    res.mode = M_QPEND;
                end else begin
                    res.kind[res.cnt] = KIND_CHAR;
                    res.chr[res.cnt] = i_data_byte;
                    res.cnt = res.cnt + 2'd1;
                end
            end
            M_QPEND: begin
                if (i_data_byte == C_QUOTE) begin
                    // doubled quote inside a quoted field
                    res.kind[res.cnt] = KIND_CHAR;
                    res.chr[res.cnt] = C_QUOTE;
                    res.cnt = res.cnt + 2'd1;
                    res.mode = M_QUOTED;
                end else begin
                    res.kind[res.cnt] = KIND_END;
                    res.cnt = res.cnt + 2'd1;
                    if (i_data_byte == C_NUL) begin
                        res.mode = M_STOP;
                    end else if (is_delim) begin
                        res.mode = M_IDLE;
                    end else begin
                        res.mode = sb_mode;
                        if (sb_emit) begin
                            res.kind[res.cnt] = sb_kind;
                            res.chr[res.cnt] = sb_chr;
                            res.cnt = res.cnt + 2'd1;
                        end
                    end
                end
            end
            M_AFTERCR: begin
                if (i_data_byte == C_LF) begin
                    res.mode = M_IDLE;
                end else begin
                    res.mode = sb_mode;
                    if (sb_emit) begin
                        res.kind[res.cnt] = sb_kind;
                        res.chr[res.cnt] = sb_chr;
                        res.cnt = res.cnt + 2'd1;
                    end
                end
            end
            M_STOP: begin
                res.mode = M_STOP;
            end
            default: begin
                res.mode = sb_mode;
                if (sb_emit) begin
                    res.kind[res.cnt] = sb_kind;
                    res.chr[res.cnt] = sb_chr;
                    res.cnt = res.cnt + 2'd1;
                end
            end
        endcase

        if (i_end_of_line) begin
            if (res.mode == M_PLAIN || res.mode == M_QUOTED || res.mode == M_QPEND) begin
                res.kind[res.cnt] = KIND_END;
                res.chr[res.cnt] = '0;
                res.cnt = res.cnt + 2'd1;
            end
            res.mode = M_IDLE;
        end
    end

    assign o_res = res;

endmodule

// ===== rtl/csv_field_tokenizer.sv =====
// Top level of the CSV field tokenizer: mode register, result queue and APB registers.
`timescale 1ns / 1ps

// Byte-serial CSV field tokenizer. One byte of a line enters per input
// transaction, with i_end_of_line on the last byte of the line; out come token
// characters (kind 0) and token-end marks (kind 1), o_last_in_run flagging the
// final result of each byte. Comma, tab and the nonzero bytes in the four
// extra-delimiter registers (APB, offsets 0x0..0xC) split fields; quoted
// fields, doubled quotes, CR/LF/CRLF and NUL termination are handled. A byte
// is parsed in the cycle it is accepted and its results (up to three) land in
// a three-entry result queue that drains one per cycle while the output is
// ready; bytes with at most one result then enter at one byte per cycle and a
// byte with more holds the input while the queue drains. The user writes
// configuration only while no transaction is outstanding; this is not enforced.
module csv_field_tokenizer
    import csvt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input byte channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_line,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_result_kind,
    output logic [7:0]         o_char_value,
    output logic               o_last_in_run,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_mode                       r_mode;
    t_delims                     r_delims;
    logic [1:0]                  r_cnt, n_cnt;
    logic [MAX_RESULTS-1:0]      r_kind, n_kind;
    logic [MAX_RESULTS-1:0]      r_last, n_last;
    logic [MAX_RESULTS-1:0][7:0] r_chr, n_chr;

    t_step_res step;
    t_reg_idx  reg_idx;
    logic      in_acc, out_acc, cfg_wr;

    csvt_step u_step (
        .i_mode        (r_mode),
        .i_data_byte   (i_data_byte),
        .i_end_of_line (i_end_of_line),
        .i_delims      (r_delims),
        .o_res         (step)
    );

    assign o_out_valid = (r_cnt != 2'd0);
    assign out_acc     = o_out_valid && i_out_ready;
    // next byte may go in once the queue is empty or its last entry leaves now
    assign o_in_ready  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;

    assign o_result_kind = r_kind[0];
    assign o_char_value  = r_chr[0];
    assign o_last_in_run = r_last[0];

    always_comb begin
        n_cnt  = r_cnt;
        n_kind = r_kind;
        n_chr  = r_chr;
        n_last = r_last;
        if (in_acc) begin
            n_cnt  = step.cnt;
            n_kind = step.kind;
            n_chr  = step.chr;
            n_last = '0;
            if (step.cnt != 2'd0) n_last[step.cnt - 2'd1] = 1'b1;
        end else if (out_acc) begin
            n_cnt  = r_cnt - 2'd1;
            n_kind = {1'b0, r_kind[MAX_RESULTS-1:1]};
            n_chr  = {8'h00, r_chr[MAX_RESULTS-1:1]};
            n_last = {1'b0, r_last[MAX_RESULTS-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_mode <= M_IDLE;
        end else begin
            r_cnt <= n_cnt;
            if (in_acc) r_mode <= step.mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_chr  <= n_chr;
        r_last <= n_last;
    end

    // APB registers
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delims <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_EXTRA_DELIM_0: r_delims[0] <= pwdata[7:0];
                REG_EXTRA_DELIM_1: r_delims[1] <= pwdata[7:0];
                REG_EXTRA_DELIM_2: r_delims[2] <= pwdata[7:0];
                REG_EXTRA_DELIM_3: r_delims[3] <= pwdata[7:0];
                default:           r_delims    <= r_delims;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_EXTRA_DELIM_0: prdata = {24'h0, r_delims[0]};
            REG_EXTRA_DELIM_1: prdata = {24'h0, r_delims[1]};
            REG_EXTRA_DELIM_2: prdata = {24'h0, r_delims[2]};
            REG_EXTRA_DELIM_3: prdata = {24'h0, r_delims[3]};
            default:           prdata = '0;
        endcase
    end

    // queue holds exactly what the accepted byte produced
    a_load_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_cnt == $past(step.cnt)))
        else $error("result queue count differs from parsed result count");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_cnt == 2'd1)) |-> o_last_in_run)
        else $error("final result of a byte not flagged last");

    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_cnt > 2'd1)) |-> !o_last_in_run)
        else $error("last flag raised before the final result of a byte");

    a_eol_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_line) |=> (r_mode == M_IDLE))
        else $error("mode not back between fields after end of line");

endmodule
